@@ sv/khtbl_pkg.sv @@
// Shared types and constants for the keyed handle table.
package khtbl_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 16;
  localparam int OCC_W    = 6;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                command;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  count;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] found_handle;
    logic [COUNT_W-1:0]  found_count;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_READ,
    S_REPLY
  } state_t;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_FOUND,
    RES_MOVED
  } res_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     match_load;
    logic     rd_last;
    logic     rd_hit;
    logic     insert;
    logic     move;
    logic     res_load;
    res_sel_t res_sel;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t command;
    logic hit;
  } dp_stat_t;

endpackage

@@ sv/khtbl_dp.sv @@
// Datapath of the keyed handle table: key cells, record memory, fill count and result register.
module khtbl_dp #(
  parameter int ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  khtbl_pkg::in_item_t in_item,
  input  khtbl_pkg::dp_ctl_t  ctl,
  output khtbl_pkg::dp_stat_t stat,
  output khtbl_pkg::out_item_t out_item
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int REC_W  = khtbl_pkg::HANDLE_W + khtbl_pkg::COUNT_W;

  khtbl_pkg::cmd_t                cmd_r;
  logic [khtbl_pkg::KEY_W-1:0]    key_r;
  logic [khtbl_pkg::HANDLE_W-1:0] handle_r;
  logic [khtbl_pkg::COUNT_W-1:0]  count_r;

  logic [khtbl_pkg::KEY_W-1:0] key_cell_r [ENTRIES];
  logic [REC_W-1:0]            rec_mem [ENTRIES];
  logic [REC_W-1:0]            rd_data_r;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx;
  logic [ENTRIES-1:0] match, lowest;
  logic [FILL_W-1:0] last_fill;
  logic [IDX_W-1:0]  fill_idx, last_idx;
  logic              full, do_insert;

  khtbl_pkg::out_item_t out_item_r, res_nxt;

  assign full      = fill_r >= FILL_W'(ENTRIES);
  assign do_insert = ctl.insert && !full;
  assign fill_idx  = fill_r[IDX_W-1:0];
  assign last_fill = fill_r - FILL_W'(1);
  assign last_idx  = last_fill[IDX_W-1:0];

  // Every key cell is compared at once; only slots below the fill count take part.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (key_cell_r[i] == key_r) && (FILL_W'(i) < fill_r);
    end
  end

  assign lowest = match & (~match + ENTRIES'(1));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (lowest[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (do_insert) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (ctl.move) begin
      fill_nxt = last_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.in_load) begin
      cmd_r    <= in_item.command;
      key_r    <= in_item.key;
      handle_r <= in_item.handle;
      count_r  <= in_item.count;
    end
    if (ctl.match_load) begin
      hit_idx_r <= hit_idx;
    end
  end

  // A remove copies the last record over the freed slot; removing the last slot copies it onto itself.
  always_ff @(posedge clk) begin
    if (do_insert) begin
      key_cell_r[fill_idx] <= key_r;
    end else if (ctl.move) begin
      key_cell_r[hit_idx_r] <= key_cell_r[last_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      rec_mem[fill_idx] <= {handle_r, count_r};
    end else if (ctl.move) begin
      rec_mem[hit_idx_r] <= rd_data_r;
    end
    if (ctl.rd_last) begin
      rd_data_r <= rec_mem[last_idx];
    end else if (ctl.rd_hit) begin
      rd_data_r <= rec_mem[hit_idx_r];
    end
  end

  always_comb begin
    res_nxt.status       = khtbl_pkg::STAT_OK;
    res_nxt.found_handle = '0;
    res_nxt.found_count  = '0;
    res_nxt.occupancy    = khtbl_pkg::OCC_W'(fill_nxt);
    case (ctl.res_sel)
      khtbl_pkg::RES_FOUND: begin
        res_nxt.found_handle = rd_data_r[REC_W-1:khtbl_pkg::COUNT_W];
        res_nxt.found_count  = rd_data_r[khtbl_pkg::COUNT_W-1:0];
      end
      khtbl_pkg::RES_MOVED: begin
        res_nxt.status = khtbl_pkg::STAT_OK;
      end
      default: begin
        case (cmd_r) inside
          khtbl_pkg::CMD_INSERT: begin
            res_nxt.status = full ? khtbl_pkg::STAT_FULL : khtbl_pkg::STAT_OK;
          end
          khtbl_pkg::CMD_REMOVE, khtbl_pkg::CMD_FIND: begin
            res_nxt.status = khtbl_pkg::STAT_MISSING;
          end
          default: begin
            res_nxt.status = khtbl_pkg::STAT_OK;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_item     = out_item_r;
  assign stat.command = cmd_r;
  assign stat.hit     = |match;

endmodule

@@ sv/khtbl_ctrl.sv @@
// Controller of the keyed handle table: operation sequencing and result handshake.
module khtbl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  khtbl_pkg::dp_stat_t stat,
  output khtbl_pkg::dp_ctl_t  ctl
);

  khtbl_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic needs_slot;

  // The result register can take a new beat when empty or when its beat leaves now.
  assign out_free   = !out_valid_r || out_ready;
  assign needs_slot = stat.hit &&
                      (stat.command == khtbl_pkg::CMD_REMOVE ||
                       stat.command == khtbl_pkg::CMD_FIND);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      khtbl_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = khtbl_pkg::S_EXEC;
        end
      end
      khtbl_pkg::S_EXEC: begin
        if (needs_slot) begin
          state_nxt = (stat.command == khtbl_pkg::CMD_REMOVE) ?
                      khtbl_pkg::S_MOVE : khtbl_pkg::S_READ;
        end else if (out_free) begin
          state_nxt = khtbl_pkg::S_IDLE;
        end
      end
      khtbl_pkg::S_MOVE: begin
        if (out_free) begin
          state_nxt = khtbl_pkg::S_IDLE;
        end
      end
      khtbl_pkg::S_READ: begin
        state_nxt = khtbl_pkg::S_REPLY;
      end
      khtbl_pkg::S_REPLY: begin
        if (out_free) begin
          state_nxt = khtbl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = khtbl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.res_sel = khtbl_pkg::RES_PLAIN;
    unique case (state_r)
      khtbl_pkg::S_IDLE: begin
        ctl.in_load = in_valid;
      end
      khtbl_pkg::S_EXEC: begin
        if (needs_slot) begin
          ctl.match_load = 1'b1;
          ctl.rd_last    = (stat.command == khtbl_pkg::CMD_REMOVE);
        end else if (out_free) begin
          ctl.res_load = 1'b1;
          ctl.insert   = (stat.command == khtbl_pkg::CMD_INSERT);
        end
      end
      khtbl_pkg::S_MOVE: begin
        if (out_free) begin
          ctl.move     = 1'b1;
          ctl.res_load = 1'b1;
          ctl.res_sel  = khtbl_pkg::RES_MOVED;
        end
      end
      khtbl_pkg::S_READ: begin
        ctl.rd_hit = 1'b1;
      end
      khtbl_pkg::S_REPLY: begin
        if (out_free) begin
          ctl.res_load = 1'b1;
          ctl.res_sel  = khtbl_pkg::RES_FOUND;
        end
      end
      default: begin
        ctl.res_sel = khtbl_pkg::RES_PLAIN;
      end
    endcase
  end

  assign out_valid_nxt = ctl.res_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= khtbl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == khtbl_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ sv/keyed_handle_table.sv @@
// Top level of the keyed handle table: controller and datapath.
//
//   channel | ports                          | beat
//   --------+--------------------------------+------------------------------------
//   in      | in_valid, in_ready, in_data    | command, key, handle, count
//   out     | out_valid, out_ready, out_data | status, found_handle, found_count,
//           |                                | occupancy
//
// Each command passes S_IDLE, taking the beat, and S_EXEC, the parallel key compare,
// where insert, a miss and the unused command end; a hit goes on to the single-port
// record memory, where a remove copies in the last record and a find reads its match.
// The next beat is taken while a finished result still waits in the output register.
// A stalled output holds the block in its final step until the register frees up.
// Reset is synchronous and empties the table at once; the stores need no clearing.
module keyed_handle_table #(
  parameter int ENTRIES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  khtbl_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output khtbl_pkg::out_item_t out_data
);

  khtbl_pkg::dp_ctl_t  ctl;
  khtbl_pkg::dp_stat_t stat;

  khtbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  khtbl_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_data),
    .ctl     (ctl),
    .stat    (stat),
    .out_item(out_data)
  );

endmodule

@@ sv/khtbl_checker.sv @@
// Port-level assertions for the keyed handle table, bound to its top level.
module khtbl_assertions (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input khtbl_pkg::out_item_t out_data
);

  // A waiting result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One item at a time: no beat is taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  // A failed operation carries no handle and no count.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != khtbl_pkg::STAT_OK |->
      out_data.found_handle == '0 && out_data.found_count == '0)
    else $error("failed operation returned data");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyed_handle_table khtbl_assertions u_khtbl_assertions (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

@@ verif/khtbl_checker.sv @@
// Watches both channels of the keyed handle table, predicts each result and compares it.
module khtbl_checker #(
  parameter int ENTRIES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  khtbl_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  khtbl_pkg::out_item_t out_data,
  output int                   n_fail,
  output int                   n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [khtbl_pkg::KEY_W-1:0]    tbl_key    [ENTRIES];
  logic [khtbl_pkg::HANDLE_W-1:0] tbl_handle [ENTRIES];
  logic [khtbl_pkg::COUNT_W-1:0]  tbl_count  [ENTRIES];
  int unsigned                    tbl_fill;

  khtbl_pkg::out_item_t awaited_results [$];
  khtbl_pkg::out_item_t want;
  int                   fail_cnt = 0;

  assign n_fail = fail_cnt;

  // Lowest slot below the fill level holding the key, or the fill level on a miss.
  function automatic int unsigned lowest_match(input logic [khtbl_pkg::KEY_W-1:0] k);
    int unsigned i;
    for (i = 0; i < tbl_fill; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return tbl_fill;
  endfunction

  function automatic khtbl_pkg::out_item_t apply_command(input khtbl_pkg::in_item_t it);
    khtbl_pkg::out_item_t r;
    int unsigned          hit;
    r = '0;
    r.status = khtbl_pkg::STAT_OK;
    case (it.command)
      khtbl_pkg::CMD_INSERT: begin
        if (tbl_fill >= ENTRIES) begin
          r.status = khtbl_pkg::STAT_FULL;
        end else begin
          tbl_key[tbl_fill]    = it.key;
          tbl_handle[tbl_fill] = it.handle;
          tbl_count[tbl_fill]  = it.count;
          tbl_fill++;
        end
      end
      khtbl_pkg::CMD_REMOVE: begin
        hit = lowest_match(it.key);
        if (hit == tbl_fill) begin
          r.status = khtbl_pkg::STAT_MISSING;
        end else begin
          tbl_fill--;
          // The last record fills the hole unless the hole is the last slot.
          if (tbl_fill > hit) begin
            tbl_key[hit]    = tbl_key[tbl_fill];
            tbl_handle[hit] = tbl_handle[tbl_fill];
            tbl_count[hit]  = tbl_count[tbl_fill];
          end
        end
      end
      khtbl_pkg::CMD_FIND: begin
        hit = lowest_match(it.key);
        if (hit == tbl_fill) begin
          r.status = khtbl_pkg::STAT_MISSING;
        end else begin
          r.found_handle = tbl_handle[hit];
          r.found_count  = tbl_count[hit];
        end
      end
      default: ;
    endcase
    r.occupancy = khtbl_pkg::OCC_W'(tbl_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tbl_fill = 0;
      awaited_results.delete();
      n_pending <= 0;
    end else begin
      // The result beat belongs to an older command, so it is retired before a new push.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no command outstanding: %p", out_data);
          fail_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status != want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
            fail_cnt++;
          end
          if (out_data.found_handle != want.found_handle) begin
            $error("found_handle mismatch: expected %0h, got %0h",
                   want.found_handle, out_data.found_handle);
            fail_cnt++;
          end
          if (out_data.found_count != want.found_count) begin
            $error("found_count mismatch: expected %0h, got %0h",
                   want.found_count, out_data.found_count);
            fail_cnt++;
          end
          if (out_data.occupancy != want.occupancy) begin
            $error("occupancy mismatch: expected %0d, got %0d",
                   want.occupancy, out_data.occupancy);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_command(in_data));
      end
      n_pending <= awaited_results.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Stimulus, receiver stalls and final verdict for the keyed handle table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES     = 32;
  localparam int N_ITEMS     = 1300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int POOL_SIZE   = 16;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  khtbl_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  khtbl_pkg::out_item_t out_data;
  int                   n_fail;
  int                   n_pending;

  int                          cycles    = 0;
  int                          sent      = 0;
  int                          burst_left = 0;
  logic [khtbl_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  // Command mix per phase: table filling, balanced, draining and lookup heavy.
  int ins_pct  [4] = '{70, 35, 15, 25};
  int rem_pct  [4] = '{12, 30, 55, 15};
  int find_pct [4] = '{14, 31, 26, 56};

  keyed_handle_table #(.ENTRIES(ENTRIES)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  khtbl_checker #(.ENTRIES(ENTRIES)) u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .n_fail   (n_fail),
    .n_pending(n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: after each random stretch a new stall pattern is drawn from four modes.
  int   rcv_left = 0;
  int   rcv_mode = 0;
  int   run_left = 0;
  logic run_lvl  = 1'b1;

  always @(posedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode <= $urandom_range(0, 3);
      rcv_left <= $urandom_range(20, 120);
    end else begin
      rcv_left <= rcv_left - 1;
    end
    case (rcv_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          run_lvl   <= ~run_lvl;
          run_left  <= $urandom_range(1, 10);
          out_ready <= ~run_lvl;
        end else begin
          run_left  <= run_left - 1;
          out_ready <= run_lvl;
        end
      end
    endcase
  end

  function automatic khtbl_pkg::in_item_t make_item(input khtbl_pkg::cmd_t c,
                                                    input logic [khtbl_pkg::KEY_W-1:0] k,
                                                    input logic [khtbl_pkg::HANDLE_W-1:0] h,
                                                    input logic [khtbl_pkg::COUNT_W-1:0] n);
    khtbl_pkg::in_item_t it;
    it.command = c;
    it.key     = k;
    it.handle  = h;
    it.count   = n;
    return it;
  endfunction

  function automatic khtbl_pkg::in_item_t random_item(input int mix);
    int                          roll;
    khtbl_pkg::cmd_t             c;
    logic [khtbl_pkg::KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct[mix]) c = khtbl_pkg::CMD_INSERT;
    else if (roll < ins_pct[mix] + rem_pct[mix]) c = khtbl_pkg::CMD_REMOVE;
    else if (roll < ins_pct[mix] + rem_pct[mix] + find_pct[mix]) c = khtbl_pkg::CMD_FIND;
    else c = khtbl_pkg::CMD_NOP;
    // Mostly pool keys so that finds and removes hit and duplicates pile up.
    if ($urandom_range(0, 99) < 80) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else k = {$urandom, $urandom};
    return make_item(c, k, $urandom, 16'($urandom));
  endfunction

  // Present one beat and hold it until taken; bursts end in a random gap.
  task automatic push_cmd(input khtbl_pkg::in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Called right after an accepted beat; drops the request and waits until the pending count is zero.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  initial begin
    int phase;
    int phase_len;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, field extremes, duplicates, swap-in remove, last slot.
    push_cmd(make_item(khtbl_pkg::CMD_FIND,   key_pool[0], '1, '1));
    push_cmd(make_item(khtbl_pkg::CMD_REMOVE, key_pool[0], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_INSERT, key_pool[0], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_INSERT, key_pool[1], '1, '1));
    push_cmd(make_item(khtbl_pkg::CMD_FIND,   key_pool[1], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_FIND,   key_pool[0], '1, '1));
    push_cmd(make_item(khtbl_pkg::CMD_INSERT, key_pool[2], 32'h1111_1111, 16'h1111));
    push_cmd(make_item(khtbl_pkg::CMD_INSERT, key_pool[2], 32'h2222_2222, 16'h2222));
    push_cmd(make_item(khtbl_pkg::CMD_FIND,   key_pool[2], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_NOP,    '1, '1, '1));
    push_cmd(make_item(khtbl_pkg::CMD_REMOVE, key_pool[0], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_FIND,   key_pool[2], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_REMOVE, key_pool[2], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_FIND,   key_pool[2], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_FIND,   key_pool[1], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_REMOVE, key_pool[2], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_FIND,   {$urandom, $urandom}, '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_REMOVE, key_pool[1], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_REMOVE, key_pool[1], '0, '0));
    push_cmd(make_item(khtbl_pkg::CMD_NOP,    '0, '0, '0));
    wait_drained();

    // Random phases, each ending with a pause until every result has come back.
    phase = 0;
    while (sent < N_ITEMS) begin
      phase_len = $urandom_range(100, 200);
      for (int i = 0; i < phase_len && sent < N_ITEMS; i++) begin
        push_cmd(random_item(phase % 4));
      end
      wait_drained();
      phase++;
    end

    repeat (12) @(posedge clk);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
